// File: rtl/core/pioc_pkg.sv
// shared types, constants and helpers of the pending i/o overlap checker
package pioc_pkg;

  localparam int unsigned QueueDepthDef = 32;

  localparam int unsigned DriveW = 8;
  localparam int unsigned LbaW   = 48;
  localparam int unsigned ByteW  = 24;
  localparam int unsigned BsizeW = 16;
  localparam int unsigned MarkW  = 8;
  localparam int unsigned TotW   = 32;
  localparam int unsigned OccW   = 6;

  localparam logic OpEnq = 1'b0;
  localparam logic OpDeq = 1'b1;

  typedef struct packed {
    logic              op;
    logic [DriveW-1:0] drive_id;
    logic [LbaW-1:0]   lba;
    logic [ByteW-1:0]  byte_count;
    logic [BsizeW-1:0] blk_bytes;
    logic              is_read;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              queue_full;
    logic [MarkW-1:0]  new_marks;
    logic [TotW-1:0]   read_total;
    logic [DriveW-1:0] head_drive_id;
    logic [LbaW-1:0]   head_lba;
    logic              head_is_read;
    logic [MarkW-1:0]  head_marks;
    logic [OccW-1:0]   occupancy;
  } out_item_t;

  // one queued request as held by a cell
  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic [LbaW-1:0]   start;
    logic [ByteW-1:0]  blocks;
    logic              rd;
    logic [MarkW-1:0]  marks;
  } entry_t;

  // new request walking down the cell row
  typedef struct packed {
    logic              valid;
    logic [DriveW-1:0] drive;
    logic [LbaW-1:0]   start;
    logic [ByteW-1:0]  blocks;
    logic              rd;
    logic [MarkW-1:0]  marks;
  } probe_t;

  // per cell report back to the controller
  typedef struct packed {
    logic             rr_hit;
    logic             stored;
    logic [MarkW-1:0] marks;
  } cell_stat_t;

  function automatic logic [MarkW-1:0] bump_mark(input logic [MarkW-1:0] v);
    bump_mark = (v == '1) ? v : v + MarkW'(1);
  endfunction

endpackage

// File: rtl/core/pioc_div.sv
// serial restoring divider giving the block count of a request
module pioc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pioc_pkg::ByteW-1:0]   dividend_i,
  input  logic [pioc_pkg::BsizeW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [pioc_pkg::ByteW-1:0]   quotient_o
);

  localparam int unsigned StepW = $clog2(pioc_pkg::ByteW);

  logic                          busy_q, done_q, zero_q;
  logic [StepW-1:0]              step_q;
  logic [pioc_pkg::BsizeW-1:0]   dsr_q, rem_q;
  logic [pioc_pkg::ByteW-1:0]    quo_q;
  logic [pioc_pkg::BsizeW:0]     rem_sh, rem_sub;

  // shift in the next dividend bit, try the subtract
  assign rem_sh  = {rem_q, quo_q[pioc_pkg::ByteW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      step_q <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        dsr_q  <= divisor_i;
        zero_q <= (divisor_i == '0);
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        if (rem_sh >= {1'b0, dsr_q}) begin
          rem_q <= rem_sub[pioc_pkg::BsizeW-1:0];
          quo_q <= {quo_q[pioc_pkg::ByteW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[pioc_pkg::BsizeW-1:0];
          quo_q <= {quo_q[pioc_pkg::ByteW-2:0], 1'b0};
        end
        if (step_q == StepW'(pioc_pkg::ByteW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + StepW'(1);
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : quo_q;

endmodule

// File: rtl/core/pioc_cell.sv
// one queue slot: holds an entry, checks a passing probe, shifts on dequeue
module pioc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  occupied_i,
  input  logic                  shift_i,
  input  pioc_pkg::entry_t      next_entry_i,
  input  pioc_pkg::probe_t      probe_i,
  output pioc_pkg::probe_t      probe_o,
  output pioc_pkg::entry_t      entry_o,
  output pioc_pkg::cell_stat_t  stat_o
);

  pioc_pkg::entry_t entry_q;
  pioc_pkg::probe_t probe_q;

  logic [pioc_pkg::LbaW:0] d_ab, d_ba;
  logic ovl, hit, rr, conflict, store;

  // [a, a+na) against [b, b+nb), no wrap
  assign d_ab = {1'b0, entry_q.start} - {1'b0, probe_i.start};
  assign d_ba = {1'b0, probe_i.start} - {1'b0, entry_q.start};
  assign ovl  = (!d_ab[pioc_pkg::LbaW] &&
                 (d_ab[pioc_pkg::LbaW-1:0] < pioc_pkg::LbaW'(probe_i.blocks))) ||
                (!d_ba[pioc_pkg::LbaW] &&
                 (d_ba[pioc_pkg::LbaW-1:0] < pioc_pkg::LbaW'(entry_q.blocks)));

  assign hit      = probe_i.valid && occupied_i && (entry_q.drive == probe_i.drive) && ovl;
  assign rr       = hit && probe_i.rd && entry_q.rd;
  assign conflict = hit && !rr;
  assign store    = probe_i.valid && !occupied_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q.valid  <= probe_i.valid && occupied_i;
      probe_q.drive  <= probe_i.drive;
      probe_q.start  <= probe_i.start;
      probe_q.blocks <= probe_i.blocks;
      probe_q.rd     <= probe_i.rd;
      probe_q.marks  <= conflict ? pioc_pkg::bump_mark(probe_i.marks) : probe_i.marks;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= next_entry_i;
    end else if (store) begin
      entry_q.drive  <= probe_i.drive;
      entry_q.start  <= probe_i.start;
      entry_q.blocks <= probe_i.blocks;
      entry_q.rd     <= probe_i.rd;
      entry_q.marks  <= probe_i.marks;
    end else if (conflict) begin
      entry_q.marks <= pioc_pkg::bump_mark(entry_q.marks);
    end
  end

  assign probe_o       = probe_q;
  assign entry_o       = entry_q;
  assign stat_o.rr_hit = rr;
  assign stat_o.stored = store;
  assign stat_o.marks  = probe_i.marks;

endmodule

// File: rtl/core/pending_io_overlap_checker_core.sv
// top level of the pending i/o overlap checker: controller and cell row
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | pioc_pkg::in_item_t
//   out     | output    | out_valid_o / out_stall_i | pioc_pkg::out_item_t
//
// dequeue and refused enqueue: no divide or probe, the item goes straight to the result state
// enqueue: the block count comes from the serial divider, then the probe walks one cell per cycle
//   up to the tail, where it is stored and the result is formed
// one item is in work at a time; the next item is taken while a result waits
// reset clears the fill count and read total; slots are only read once written
// a stalled result holds in the output register until taken
module pending_io_overlap_checker_core #(
  parameter int unsigned QUEUE_DEPTH = pioc_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pioc_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pioc_pkg::out_item_t  out_item_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_RESULT
  } state_e;

  state_e                     state_q;
  logic [CntW-1:0]            cnt_q;
  logic [pioc_pkg::TotW-1:0]  rdtot_q;
  logic                       out_valid_q;
  pioc_pkg::out_item_t        out_q, res_q;
  pioc_pkg::out_item_t        idle_res, res_fin;
  pioc_pkg::in_item_t         req_q;
  pioc_pkg::probe_t           probe_q;

  logic                       div_start, div_done;
  logic [pioc_pkg::ByteW-1:0] div_quo;
  logic                       shift, full;

  // probe chain: element i feeds cell i
  pioc_pkg::probe_t     chain [QUEUE_DEPTH+1];
  pioc_pkg::entry_t     cell_entry [QUEUE_DEPTH];
  pioc_pkg::cell_stat_t cell_stat [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stored_vec;

  logic                       rr_any, st_any;
  logic [pioc_pkg::MarkW-1:0] st_marks;

  assign full       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign in_stall_o = (state_q != ST_IDLE);
  assign div_start  = (state_q == ST_IDLE) && in_valid_i &&
                      (in_item_i.op == pioc_pkg::OpEnq) && !full;
  // dequeue pops the head by sliding every cell one place toward it
  assign shift      = (state_q == ST_IDLE) && in_valid_i &&
                      (in_item_i.op == pioc_pkg::OpDeq) && (cnt_q != '0);

  pioc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_item_i.byte_count),
    .divisor_i  (in_item_i.blk_bytes),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign chain[0] = probe_q;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pioc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .occupied_i   (CntW'(i) < cnt_q),
      .shift_i      (shift),
      .next_entry_i (cell_entry[(i + 1 < QUEUE_DEPTH) ? i + 1 : i]),
      .probe_i      (chain[i]),
      .probe_o      (chain[i+1]),
      .entry_o      (cell_entry[i]),
      .stat_o       (cell_stat[i])
    );
    assign stored_vec[i] = cell_stat[i].stored;
  end

  // only one cell sees the probe in a cycle, so plain or-reduction suffices
  always_comb begin
    rr_any   = 1'b0;
    st_any   = 1'b0;
    st_marks = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rr_any = rr_any | cell_stat[i].rr_hit;
      st_any = st_any | cell_stat[i].stored;
      if (cell_stat[i].stored) begin
        st_marks = st_marks | cell_stat[i].marks;
      end
    end
  end

  // result of an item that needs no probe: dequeue or refused enqueue
  always_comb begin
    idle_res = '0;
    if (in_item_i.op == pioc_pkg::OpDeq) begin
      if (cnt_q != '0) begin
        idle_res.accepted      = 1'b1;
        idle_res.head_drive_id = cell_entry[0].drive;
        idle_res.head_lba      = cell_entry[0].start;
        idle_res.head_is_read  = cell_entry[0].rd;
        idle_res.head_marks    = cell_entry[0].marks;
      end
    end else if (full) begin
      idle_res.queue_full = 1'b1;
    end
  end

  // running total and fill level are taken as the result leaves
  always_comb begin
    res_fin            = res_q;
    res_fin.read_total = rdtot_q;
    res_fin.occupancy  = pioc_pkg::OccW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rdtot_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
      req_q       <= '0;
      probe_q     <= '0;
    end else begin
      // the probe enters the row for one cycle once the block count is ready
      probe_q.valid <= (state_q == ST_DIV) && div_done;
      if ((state_q == ST_RESULT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // read-read overlaps count globally, saturating
      if (rr_any && (rdtot_q != '1)) begin
        rdtot_q <= rdtot_q + pioc_pkg::TotW'(1);
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            res_q <= idle_res;
            if (in_item_i.op == pioc_pkg::OpDeq) begin
              if (cnt_q != '0) begin
                cnt_q <= cnt_q - CntW'(1);
              end
              state_q <= ST_RESULT;
            end else if (full) begin
              state_q <= ST_RESULT;
            end else begin
              req_q   <= in_item_i;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            probe_q.drive  <= req_q.drive_id;
            probe_q.start  <= req_q.lba;
            probe_q.blocks <= div_quo;
            probe_q.rd     <= req_q.is_read;
            probe_q.marks  <= '0;
            state_q        <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          // the probe settles in the first free cell, which is the tail
          if (st_any) begin
            res_q.accepted  <= 1'b1;
            res_q.new_marks <= st_marks;
            cnt_q           <= cnt_q + CntW'(1);
            state_q         <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q   <= res_fin;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(stored_vec))
    else $error("more than one cell stored the probe");

  a_store_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_any |-> (state_q == ST_PROBE))
    else $error("probe stored outside the probe phase");

  a_store_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_any |=> (state_q == ST_RESULT))
    else $error("store did not lead to a result");

  a_div_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

endmodule
